### hdl/uvpm_pkg.sv
// ----------------------------------------------------------------------------
// uvpm_pkg
// Types, constants and the arctangent table shared by the uv mapping pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package uvpm_pkg;

  // cordic depth and table size
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // cordic datapath width: q4.20 inputs plus gain headroom
  localparam int CW = 28;

  // square root: 24 result bits, one per stage, plus the load stage
  localparam int SQ_BITS = 24;
  localparam int SQ_LAT  = SQ_BITS + 1;
  localparam int CO_LAT  = NSTG + 1;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // configuration register index and mode codes
  localparam logic REG_MODE = 1'b0;
  localparam logic MODE_CYL = 1'b0;
  localparam logic MODE_SPH = 1'b1;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } out_item_t;

  // atan(2^-i) as a phase, 2^32 per turn
  function automatic logic [31:0] atan_phase(input int i);
    logic [31:0] p;
    case (i)
      0:       p = 32'h20000000;
      1:       p = 32'h12E4051D;
      2:       p = 32'h09FB385B;
      3:       p = 32'h051111D4;
      4:       p = 32'h028B0D43;
      5:       p = 32'h0145D7E1;
      6:       p = 32'h00A2F61E;
      7:       p = 32'h00517C55;
      8:       p = 32'h0028BE53;
      9:       p = 32'h00145F2E;
      10:      p = 32'h000A2F98;
      11:      p = 32'h000517CC;
      12:      p = 32'h00028BE6;
      13:      p = 32'h000145F3;
      14:      p = 32'h0000A2F9;
      15:      p = 32'h0000517C;
      16:      p = 32'h000028BE;
      17:      p = 32'h0000145F;
      18:      p = 32'h00000A2F;
      19:      p = 32'h00000517;
      20:      p = 32'h0000028B;
      21:      p = 32'h00000145;
      22:      p = 32'h000000A2;
      23:      p = 32'h00000051;
      default: p = 32'h00000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/uvpm_isqrt.sv
// ----------------------------------------------------------------------------
// uvpm_isqrt
// Pipelined restoring square root of sq * 2^16, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module uvpm_isqrt (
  input  wire logic                          clk,
  input  wire logic [31:0]                   sq_in,
  output logic      [uvpm_pkg::SQ_BITS-1:0]  root_out
);
  import uvpm_pkg::*;

  logic [47:0]        rad_r  [SQ_BITS+1];
  logic [26:0]        rem_r  [SQ_BITS+1];
  logic [SQ_BITS-1:0] root_r [SQ_BITS+1];

  // load stage
  always_ff @(posedge clk) begin
    rad_r[0]  <= {sq_in, 16'h0000};
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  // one digit per stage
  for (genvar k = 1; k <= SQ_BITS; k++) begin : g_stage
    logic [26:0] part;
    logic [26:0] trial;
    logic [26:0] diff;

    always_comb begin
      part  = {rem_r[k-1][24:0], rad_r[k-1][47-2*(k-1) -: 2]};
      trial = {2'b00, root_r[k-1][SQ_BITS-2:0], 2'b01};
      diff  = part - trial;
    end

    always_ff @(posedge clk) begin
      rad_r[k] <= rad_r[k-1];
      if (part >= trial) begin
        rem_r[k]  <= diff;
        root_r[k] <= {root_r[k-1][SQ_BITS-2:0], 1'b1};
      end else begin
        rem_r[k]  <= part;
        root_r[k] <= {root_r[k-1][SQ_BITS-2:0], 1'b0};
      end
    end
  end

  assign root_out = root_r[SQ_BITS];

endmodule

`default_nettype wire

### hdl/uvpm_cordic.sv
// ----------------------------------------------------------------------------
// uvpm_cordic
// Pipelined vectoring cordic: phase of atan2(b, a), 2^32 per turn.
// ----------------------------------------------------------------------------
`default_nettype none

module uvpm_cordic (
  input  wire logic                             clk,
  input  wire logic signed [uvpm_pkg::CW-1:0]   a_in,
  input  wire logic signed [uvpm_pkg::CW-1:0]   b_in,
  output logic             [31:0]               phase_out
);
  import uvpm_pkg::*;

  logic signed [CW-1:0] a_r  [NSTG+1];
  logic signed [CW-1:0] b_r  [NSTG+1];
  logic        [31:0]   ph_r [NSTG+1];

  // half-turn pre-rotation for a negative first coordinate
  always_ff @(posedge clk) begin
    if (a_in < 0) begin
      a_r[0]  <= -a_in;
      b_r[0]  <= -b_in;
      ph_r[0] <= HALF_TURN;
    end else begin
      a_r[0]  <= a_in;
      b_r[0]  <= b_in;
      ph_r[0] <= '0;
    end
  end

  // micro-rotations toward b = 0
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;

    assign da = b_r[i] >>> i;
    assign db = a_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (b_r[i] >= 0) begin
        a_r[i+1]  <= a_r[i] + da;
        b_r[i+1]  <= b_r[i] - db;
        ph_r[i+1] <= ph_r[i] + atan_phase(i);
      end else begin
        a_r[i+1]  <= a_r[i] - da;
        b_r[i+1]  <= b_r[i] + db;
        ph_r[i+1] <= ph_r[i] - atan_phase(i);
      end
    end
  end

  assign phase_out = ph_r[NSTG];

endmodule

`default_nettype wire

### hdl/uv_projection_mapping_unit.sv
// ----------------------------------------------------------------------------
// uv_projection_mapping_unit
// Maps a vertex (x, y, z, q4.12) to texture coordinates (u, v, q0.16),
// cylindrical or spherical projection.
//
//   channel   ports                               handshake
//   input     start, busy, in_item                start & !busy
//   result    out_valid, out_item                 strobe, one cycle
//   config    psel penable pwrite paddr pwdata    apb, pready tied high
//             prdata pready
//
// One item per cycle; busy is always low. Each item passes through the input,
// square and sum registers, the 24-stage square root and the cordic stages.
// Reset clears the valid bits and the mode register (cylindrical).
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_projection_mapping_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire uvpm_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output uvpm_pkg::out_item_t       out_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import uvpm_pkg::*;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef struct packed {
    logic        mode;
    logic        uzero;
    logic        rzero;
    logic        yneg;
    logic [15:0] cylv;
  } side_t;

  logic mode_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CYL;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  assign prdata = {31'h0, (paddr[2] == REG_MODE) ? mode_r : 1'b0};
  assign pready = 1'b1;
  assign busy   = 1'b0;

  // input capture, squares, sum
  logic        v0_r, v1_r, v2_r;
  vtx_t        p0_r, p1_r, p2_r;
  logic [31:0] xx_r, zz_r, sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= '{mode: mode_r, x: in_item.vertex_x, y: in_item.vertex_y, z: in_item.vertex_z};
    p1_r <= p0_r;
    xx_r <= 32'(p0_r.x * p0_r.x);
    zz_r <= 32'(p0_r.z * p0_r.z);
    p2_r <= p1_r;
    sq_r <= xx_r + zz_r;
  end

  // square root
  logic [SQ_BITS-1:0] root;

  uvpm_isqrt u_isqrt (
    .clk      (clk),
    .sq_in    (sq_r),
    .root_out (root)
  );

  // side data alongside the square root
  logic vs_r [SQ_LAT];
  vtx_t ps_r [SQ_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_LAT; k++) vs_r[k] <= 1'b0;
    end else begin
      vs_r[0] <= v2_r;
      for (int k = 1; k < SQ_LAT; k++) vs_r[k] <= vs_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    ps_r[0] <= p2_r;
    for (int k = 1; k < SQ_LAT; k++) ps_r[k] <= ps_r[k-1];
  end

  // cordic operands and per-item flags
  vtx_t                 pv;
  logic signed [CW-1:0] ua, ub, va, vb;
  logic signed [16:0]   ysum;
  side_t                side;

  always_comb begin
    pv   = ps_r[SQ_LAT-1];
    ua   = CW'({{(CW-24){pv.x[15]}}, pv.x, 8'h00});
    ub   = CW'({{(CW-24){pv.z[15]}}, pv.z, 8'h00});
    va   = CW'({{(CW-24){pv.y[15]}}, pv.y, 8'h00});
    vb   = CW'({{(CW-SQ_BITS){1'b0}}, root});
    ysum = 17'(pv.y) + 17'sd2048;
    side.mode  = pv.mode;
    side.uzero = (pv.x == 0) && (pv.z == 0);
    side.rzero = (root == '0);
    side.yneg  = pv.y[15];
    if (ysum < 0) begin
      side.cylv = 16'h0000;
    end else if (ysum > 17'sd4095) begin
      side.cylv = 16'hFFFF;
    end else begin
      side.cylv = {ysum[11:0], 4'h0};
    end
  end

  logic [31:0] phu, phv;

  uvpm_cordic u_cordic_u (
    .clk       (clk),
    .a_in      (ua),
    .b_in      (ub),
    .phase_out (phu)
  );

  uvpm_cordic u_cordic_v (
    .clk       (clk),
    .a_in      (va),
    .b_in      (vb),
    .phase_out (phv)
  );

  // flags alongside the cordics
  logic  vc_r [CO_LAT];
  side_t sc_r [CO_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CO_LAT; k++) vc_r[k] <= 1'b0;
    end else begin
      vc_r[0] <= vs_r[SQ_LAT-1];
      for (int k = 1; k < CO_LAT; k++) vc_r[k] <= vc_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    sc_r[0] <= side;
    for (int k = 1; k < CO_LAT; k++) sc_r[k] <= sc_r[k-1];
  end

  // result select
  side_t     sf;
  out_item_t res_nxt;
  logic      out_valid_r;
  out_item_t out_item_r;

  always_comb begin
    sf = sc_r[CO_LAT-1];
    res_nxt.tex_u = sf.uzero ? 16'h0000 : phu[31:16];
    if (sf.mode == MODE_CYL) begin
      res_nxt.tex_v = sf.cylv;
    end else if (sf.rzero) begin
      res_nxt.tex_v = sf.yneg ? 16'hFFFF : 16'h0000;
    end else if (phv[31]) begin
      res_nxt.tex_v = 16'h0000;
    end else begin
      res_nxt.tex_v = phv[30:15];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vc_r[CO_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
